// ===== rtl/cvl_pkg.sv =====
// ----------------------------------------------------------------------------
// cvl_pkg
// Shared types and constants for the compacting value list.
// ----------------------------------------------------------------------------
package cvl_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IN_W     = 40;
  localparam int OUT_W    = 48;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef struct packed {
    logic              append;
    logic              remove;
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  index;
  } cell_ctrl_t;

  typedef struct packed {
    logic              occ;
    logic              found;
    logic              rd_hit;
    logic [DATA_W-1:0] rd_data;
  } cell_fwd_t;

  typedef struct packed {
    logic              occ;
    logic [DATA_W-1:0] data;
  } cell_bwd_t;

endpackage

// ===== rtl/compacting_value_list_core.sv =====
// ----------------------------------------------------------------------------
// compacting_value_list_core
// Ordered list of signed 32-bit values with append, remove-first-match and
// indexed read, built as a row of slot cells.
// ----------------------------------------------------------------------------
// Each transfer carries one operation and yields one result, registered and
// presented in the following cycle; a new operation is taken every cycle as
// long as the previous result has been taken or is taken in the same cycle.
// All slot cells compare, select and shift in parallel. The list holds 64
// entries; no clearing pass is needed after reset.
module compacting_value_list_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [cvl_pkg::IN_W-1:0]   in_tdata,   // cmd[1:0], value[33:2], index[39:34]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [cvl_pkg::OUT_W-1:0]  out_tdata   // read_data[31:0], count[38:32],
                                                 // status[40:39], zero[47:41]
);
  import cvl_pkg::*;

  logic                  in_fire;
  cmd_t                  cmd;
  logic [DATA_W-1:0]     value;
  logic [IDX_W-1:0]      index;
  cell_ctrl_t            ctrl;
  cell_fwd_t             fwd [CAPACITY+1];
  cell_bwd_t             bwd [CAPACITY+1];

  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]     rd_data_r, rd_data_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  status_t               status_r, status_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign cmd   = cmd_t'(in_tdata[1:0]);
  assign value = in_tdata[2 +: DATA_W];
  assign index = in_tdata[2 + DATA_W +: IDX_W];

  always_comb begin
    ctrl.append = in_fire && (cmd == CMD_APPEND);
    ctrl.remove = in_fire && (cmd == CMD_REMOVE);
    ctrl.value  = value;
    ctrl.index  = index;
  end

  assign fwd[0]        = '{occ: 1'b1, found: 1'b0, rd_hit: 1'b0, rd_data: '0};
  assign bwd[CAPACITY] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    cvl_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .pos_i  (IDX_W'(g)),
      .ctrl_i (ctrl),
      .fwd_i  (fwd[g]),
      .fwd_o  (fwd[g+1]),
      .bwd_i  (bwd[g+1]),
      .bwd_o  (bwd[g])
    );
  end

  always_comb begin
    rd_data_nxt   = rd_data_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      rd_data_nxt   = '0;
      status_nxt    = ST_OK;
      unique case (cmd)
        CMD_APPEND: begin
          if (fwd[CAPACITY].occ) begin
            status_nxt = ST_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_REMOVE: begin
          if (fwd[CAPACITY].found) begin
            count_nxt = count_r - CNT_W'(1);
          end else begin
            status_nxt = ST_NOMATCH;
          end
        end
        CMD_READ: begin
          if (fwd[CAPACITY].rd_hit) begin
            rd_data_nxt = fwd[CAPACITY].rd_data;
          end else begin
            status_nxt = ST_RANGE;
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
      status_r    <= ST_OK;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      status_r    <= status_nxt;
    end
    rd_data_r <= rd_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({status_r, count_r, rd_data_r});

endmodule

// ===== rtl/cvl_cell.sv =====
// ----------------------------------------------------------------------------
// cvl_cell
// One list slot: holds an entry and its occupied flag, compares against the
// operand, and shifts down from its upper neighbor on a remove.
// ----------------------------------------------------------------------------
module cvl_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [cvl_pkg::IDX_W-1:0] pos_i,
  input  cvl_pkg::cell_ctrl_t     ctrl_i,
  input  cvl_pkg::cell_fwd_t      fwd_i,
  output cvl_pkg::cell_fwd_t      fwd_o,
  input  cvl_pkg::cell_bwd_t      bwd_i,
  output cvl_pkg::cell_bwd_t      bwd_o
);
  import cvl_pkg::*;

  logic              occ_r, occ_nxt;
  logic [DATA_W-1:0] entry_r, entry_nxt;
  logic              hit;
  logic              sel;

  assign hit = occ_r && (entry_r == ctrl_i.value);
  assign sel = occ_r && (pos_i == ctrl_i.index);

  always_comb begin
    fwd_o.occ     = occ_r;
    fwd_o.found   = fwd_i.found | hit;
    fwd_o.rd_hit  = fwd_i.rd_hit | sel;
    fwd_o.rd_data = fwd_i.rd_data | (sel ? entry_r : '0);
    bwd_o.occ     = occ_r;
    bwd_o.data    = entry_r;
  end

  always_comb begin
    occ_nxt   = occ_r;
    entry_nxt = entry_r;
    if (ctrl_i.append && !occ_r && fwd_i.occ) begin
      occ_nxt   = 1'b1;
      entry_nxt = ctrl_i.value;
    end else if (ctrl_i.remove && fwd_o.found) begin
      occ_nxt   = bwd_i.occ;
      entry_nxt = bwd_i.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
    entry_r <= entry_nxt;
  end

endmodule

// ===== sim/cvl_list_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cvl_list_checker
// Passive scoreboard for the compacting value list: watches both stream
// channels, keeps its own copy of the list and its count, and compares every
// result transfer with the oldest predicted result.
// ----------------------------------------------------------------------------
module cvl_list_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [cvl_pkg::IN_W-1:0]  in_tdata,   // cmd[1:0], value[33:2], index[39:34]
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [cvl_pkg::OUT_W-1:0] out_tdata,  // read_data[31:0], count[38:32],
                                                // status[40:39], zero[47:41]
  output int                        error_count,
  output int                        pending_count
);
  import cvl_pkg::*;

  typedef struct {
    logic [DATA_W-1:0] read_data;
    logic [CNT_W-1:0]  count;
    status_t           status;
  } list_result_t;

  logic [DATA_W-1:0] list_mem [CAPACITY];
  int                list_len;
  list_result_t      expected_results [$];

  initial begin
    error_count   = 0;
    pending_count = 0;
    list_len      = 0;
  end

  task automatic apply_list_op(input cmd_t op, input logic [DATA_W-1:0] val,
                               input logic [IDX_W-1:0] idx, output list_result_t res);
    int hit_pos;
    res.read_data = '0;
    res.status    = ST_OK;
    hit_pos       = -1;
    case (op)
      CMD_APPEND: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      CMD_REMOVE: begin
        for (int i = 0; i < list_len; i++)
          if (hit_pos < 0 && list_mem[i] == val) hit_pos = i;
        if (hit_pos < 0) begin
          res.status = ST_NOMATCH;
        end else begin
          for (int i = hit_pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
          list_len--;
        end
      end
      CMD_READ: begin
        if (int'(idx) < list_len) res.read_data = list_mem[idx];
        else res.status = ST_RANGE;
      end
      default: ;
    endcase
    res.count = CNT_W'(list_len);
  endtask

  task automatic report_field(input string field, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
    error_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    list_result_t res;
    if (!rst_n) begin
      list_len = 0;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.read_data = out_tdata[DATA_W-1:0];
        got.count     = out_tdata[DATA_W +: CNT_W];
        got.status    = status_t'(out_tdata[DATA_W+CNT_W +: 2]);
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: result transfer with none expected, expected none, actual %0h",
                   $time, out_tdata);
        end else begin
          want = expected_results.pop_front();
          if (got.read_data !== want.read_data)
            report_field("read_data", want.read_data, got.read_data);
          if (got.count !== want.count)
            report_field("count", DATA_W'(want.count), DATA_W'(got.count));
          if (got.status !== want.status)
            report_field("status", DATA_W'(want.status), DATA_W'(got.status));
        end
      end
      if (in_tvalid && in_tready) begin
        apply_list_op(cmd_t'(in_tdata[1:0]), in_tdata[2 +: DATA_W],
                      in_tdata[DATA_W+2 +: IDX_W], res);
        expected_results.push_back(res);
      end
    end
    pending_count = expected_results.size();
  end

endmodule

// ===== sim/tb_compacting_value_list_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_compacting_value_list_core
// Stimulus and verdict for the compacting value list core: a directed run
// through the list's edge cases, then random phases that drive the count
// between empty and full, with random idling on both channels and one long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_compacting_value_list_core;
  import cvl_pkg::*;

  localparam int LONG_HOLD  = 300;
  localparam int PHASE_LEN  = 80;
  localparam int NUM_PHASES = 10;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;   // cmd[1:0], value[33:2], index[39:34]
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;  // read_data[31:0], count[38:32], status[40:39]
  int                error_count;
  int                pending_count;
  logic              quiet_phase   = 1'b0;
  logic              long_hold_req = 1'b0;

  logic [DATA_W-1:0] value_pool [12] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h0000_0001, 32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
    32'h0000_002A, 32'hFFFF_FF00, 32'h1234_5678, 32'h0F0F_0F0F
  };

  int append_pct [NUM_PHASES] = '{100, 20, 60, 80, 95, 30, 10, 50, 90, 40};

  always #5 clk = ~clk;

  compacting_value_list_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  cvl_list_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  task automatic send_op(input cmd_t op, input logic [DATA_W-1:0] val,
                         input logic [IDX_W-1:0] idx);
    int gap;
    gap = (!quiet_phase && $urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {idx, val, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 6) return value_pool[$urandom_range(0, 11)];
    return $urandom;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 9) < 7) return IDX_W'($urandom_range(0, 31));
    return IDX_W'($urandom_range(0, 63));
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    bit long_hold_taken;
    int n;
    long_hold_taken = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 10);
        out_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        if (!quiet_phase) repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int r;
    int rw_pct;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed edge cases
    send_op(CMD_READ,   32'h0000_0000, 6'd0);
    send_op(CMD_REMOVE, 32'h0000_0005, 6'd0);
    send_op(CMD_NONE,   32'hFFFF_FFFF, 6'd63);
    send_op(CMD_APPEND, 32'h8000_0000, 6'd63);
    send_op(CMD_APPEND, 32'h7FFF_FFFF, 6'd0);
    send_op(CMD_APPEND, 32'h0000_0000, 6'd0);
    send_op(CMD_APPEND, 32'hFFFF_FFFF, 6'd0);
    send_op(CMD_APPEND, 32'h7FFF_FFFF, 6'd0);
    send_op(CMD_READ,   32'hFFFF_FFFF, 6'd0);
    send_op(CMD_READ,   32'h0000_0000, 6'd4);
    send_op(CMD_READ,   32'h0000_0000, 6'd5);
    send_op(CMD_READ,   32'h0000_0000, 6'd63);
    send_op(CMD_REMOVE, 32'h7FFF_FFFF, 6'd0);
    send_op(CMD_READ,   32'h0000_0000, 6'd1);
    send_op(CMD_REMOVE, 32'h1234_5678, 6'd0);
    send_op(CMD_REMOVE, 32'h7FFF_FFFF, 6'd0);
    send_op(CMD_REMOVE, 32'h8000_0000, 6'd0);
    send_op(CMD_READ,   32'h0000_0000, 6'd0);
    send_op(CMD_APPEND, 32'hA5A5_A5A5, 6'd0);
    send_op(CMD_REMOVE, 32'hA5A5_A5A5, 6'd0);
    send_op(CMD_REMOVE, 32'h0000_0000, 6'd0);
    send_op(CMD_REMOVE, 32'hFFFF_FFFF, 6'd0);
    send_op(CMD_READ,   32'h0000_0000, 6'd0);

    // random phases that swing the count between empty and full
    for (int p = 0; p < NUM_PHASES; p++) begin
      quiet_phase   = (p == NUM_PHASES - 1);
      if (p == 2) long_hold_req = 1'b1;
      rw_pct = 3 + (97 * append_pct[p]) / 100;
      for (int k = 0; k < PHASE_LEN; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) send_op(CMD_NONE, $urandom, IDX_W'($urandom));
        else if (r < rw_pct) send_op(CMD_APPEND, pick_value(), IDX_W'($urandom));
        else if (r % 2 == 0) send_op(CMD_REMOVE, pick_value(), IDX_W'($urandom));
        else send_op(CMD_READ, $urandom, pick_index());
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
